// ----- hdl/glos_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid line-of-sight package
// Shared constants, types and address helpers for the line-of-sight core.
// ----------------------------------------------------------------------------
package glos_pkg;

  // Grid geometry.
  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 256;
  localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(MAP_CELLS);

  // Field widths.
  localparam int COORD_W = 8;
  localparam int COST_W  = 8;
  // Signed width of the walk error term and the octant bias.
  localparam int ERR_W   = COORD_W + 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COST_W-1:0]  cost_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic signed [ERR_W-1:0] err_t;

  localparam cost_t THRESH_RESET = cost_t'(254);

  // Transaction operation codes.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Walk sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GOAL,
    S_STEP,
    S_CHECK,
    S_DONE
  } walk_state_t;

  // Request bundle from the walker to the cost memory.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    cost_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } ram_req_t;

  // Linear address of a cell, row major.
  function automatic addr_t cell_addr(coord_t x, coord_t y);
    return ADDR_W'(int'(y) * MAP_WIDTH + int'(x));
  endfunction

  // True when the cell lies inside the grid.
  function automatic logic in_grid(coord_t x, coord_t y);
    return (int'(x) < MAP_WIDTH) && (int'(y) < MAP_HEIGHT);
  endfunction

endpackage

// ----- hdl/glos_cost_ram.sv -----
// ----------------------------------------------------------------------------
// Cost grid memory
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module glos_cost_ram (
  input  logic               clk,
  input  glos_pkg::ram_req_t req,
  output glos_pkg::cost_t    rd_data
);

  glos_pkg::cost_t mem [glos_pkg::MAP_CELLS];
  glos_pkg::cost_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/glos_walker.sv -----
// ----------------------------------------------------------------------------
// Line walker
// Sequences grid writes and Bresenham-style line walks over the cost memory,
// and holds the result register.
// ----------------------------------------------------------------------------
module glos_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  glos_pkg::cost_t    threshold,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  glos_pkg::coord_t   in_cell_x,
  input  glos_pkg::coord_t   in_cell_y,
  input  glos_pkg::cost_t    in_cell_cost,
  input  glos_pkg::coord_t   in_from_x,
  input  glos_pkg::coord_t   in_from_y,
  input  glos_pkg::coord_t   in_to_x,
  input  glos_pkg::coord_t   in_to_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible,
  output glos_pkg::ram_req_t ram_req,
  input  glos_pkg::cost_t    ram_rd_data
);

  localparam int PAD_W = glos_pkg::ERR_W - glos_pkg::COORD_W;

  glos_pkg::walk_state_t state_r, state_nxt;

  // Walk registers.
  glos_pkg::coord_t x_r, x_nxt, y_r, y_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  glos_pkg::coord_t a_maj_r, a_maj_nxt, a_min_r, a_min_nxt;
  logic             oct_x_r, oct_x_nxt;
  logic             x_neg_r, x_neg_nxt, y_neg_r, y_neg_nxt;
  logic             x_mv_r, x_mv_nxt, y_mv_r, y_mv_nxt;
  glos_pkg::err_t   e_r, e_nxt, tau_r, tau_nxt;
  glos_pkg::cost_t  goal_r, goal_nxt;
  logic             res_r, res_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt, out_visible_r, out_visible_nxt;

  logic             in_accept, out_free, is_query;
  logic             query_bad, same_cell;
  glos_pkg::coord_t ax, ay;
  logic             oct_in;
  logic signed [glos_pkg::ERR_W:0] twice_e, tau_ext;
  logic             maj_step, min_step;
  logic             move_x, move_y;
  glos_pkg::coord_t x_step, y_step;
  logic             blocked, at_end;

  // Handshake.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == glos_pkg::S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_query  = (in_operation == glos_pkg::OP_QUERY);

  // Query setup: spans, directions and octant.
  always_comb begin
    ax        = (in_to_x < in_from_x) ? (in_from_x - in_to_x) : (in_to_x - in_from_x);
    ay        = (in_to_y < in_from_y) ? (in_from_y - in_to_y) : (in_to_y - in_from_y);
    oct_in    = ax > ay;
    query_bad = !glos_pkg::in_grid(in_from_x, in_from_y) ||
                !glos_pkg::in_grid(in_to_x, in_to_y);
    same_cell = (in_from_x == in_to_x) && (in_from_y == in_to_y);
  end

  // One step of the error rule.
  always_comb begin
    twice_e  = {e_r, 1'b0};
    tau_ext  = {tau_r[glos_pkg::ERR_W-1], tau_r};
    maj_step = twice_e > tau_ext;
    min_step = twice_e < tau_ext;
    if (oct_x_r) begin
      move_x = !min_step;
      move_y = !maj_step;
    end else begin
      move_x = !maj_step;
      move_y = !min_step;
    end
    x_step = x_neg_r ? (x_r - glos_pkg::coord_t'(1)) : (x_r + glos_pkg::coord_t'(1));
    y_step = y_neg_r ? (y_r - glos_pkg::coord_t'(1)) : (y_r + glos_pkg::coord_t'(1));
  end

  // Cell check on returned memory data.
  always_comb begin
    blocked = (ram_rd_data >= threshold) && (ram_rd_data >= goal_r);
    at_end  = oct_x_r ? (x_r == tx_r) : (y_r == ty_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      glos_pkg::S_IDLE: begin
        if (in_accept && is_query) begin
          if (query_bad || same_cell) begin
            state_nxt = glos_pkg::S_DONE;
          end else begin
            state_nxt = glos_pkg::S_GOAL;
          end
        end
      end
      glos_pkg::S_GOAL: begin
        state_nxt = glos_pkg::S_STEP;
      end
      glos_pkg::S_STEP: begin
        state_nxt = glos_pkg::S_CHECK;
      end
      glos_pkg::S_CHECK: begin
        if (blocked || at_end) begin
          state_nxt = glos_pkg::S_DONE;
        end else begin
          state_nxt = glos_pkg::S_STEP;
        end
      end
      glos_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = glos_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = glos_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, memory requests and result register.
  always_comb begin
    x_nxt           = x_r;
    y_nxt           = y_r;
    tx_nxt          = tx_r;
    ty_nxt          = ty_r;
    a_maj_nxt       = a_maj_r;
    a_min_nxt       = a_min_r;
    oct_x_nxt       = oct_x_r;
    x_neg_nxt       = x_neg_r;
    y_neg_nxt       = y_neg_r;
    x_mv_nxt        = x_mv_r;
    y_mv_nxt        = y_mv_r;
    e_nxt           = e_r;
    tau_nxt         = tau_r;
    goal_nxt        = goal_r;
    res_nxt         = res_r;
    ram_req         = '0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_visible_nxt = out_visible_r;

    case (state_r)
      glos_pkg::S_IDLE: begin
        if (in_accept && !is_query) begin
          // A grid write always answers with not visible.
          ram_req.wr_en   = glos_pkg::in_grid(in_cell_x, in_cell_y);
          ram_req.wr_addr = glos_pkg::cell_addr(in_cell_x, in_cell_y);
          ram_req.wr_data = in_cell_cost;
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b0;
        end
        if (in_accept && is_query) begin
          // Fetch the goal cell cost first.
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = glos_pkg::cell_addr(in_to_x, in_to_y);
          x_nxt     = in_from_x;
          y_nxt     = in_from_y;
          tx_nxt    = in_to_x;
          ty_nxt    = in_to_y;
          oct_x_nxt = oct_in;
          x_neg_nxt = in_to_x < in_from_x;
          y_neg_nxt = in_to_y < in_from_y;
          x_mv_nxt  = in_to_x != in_from_x;
          y_mv_nxt  = in_to_y != in_from_y;
          a_maj_nxt = oct_in ? ax : ay;
          a_min_nxt = oct_in ? ay : ax;
          tau_nxt   = glos_pkg::err_t'({{PAD_W{1'b0}}, oct_in ? ay : ax}) -
                      glos_pkg::err_t'({{PAD_W{1'b0}}, oct_in ? ax : ay});
          e_nxt     = '0;
          res_nxt   = !query_bad && same_cell;
        end
      end
      glos_pkg::S_GOAL: begin
        goal_nxt = ram_rd_data;
      end
      glos_pkg::S_STEP: begin
        // Advance one cell and read it.
        if (move_x && x_mv_r) begin
          x_nxt = x_step;
        end
        if (move_y && y_mv_r) begin
          y_nxt = y_step;
        end
        if (maj_step) begin
          e_nxt = e_r - glos_pkg::err_t'({{PAD_W{1'b0}}, a_min_r});
        end else if (min_step) begin
          e_nxt = e_r + glos_pkg::err_t'({{PAD_W{1'b0}}, a_maj_r});
        end else begin
          e_nxt = e_r + glos_pkg::err_t'({{PAD_W{1'b0}}, a_maj_r}) -
                  glos_pkg::err_t'({{PAD_W{1'b0}}, a_min_r});
        end
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = glos_pkg::cell_addr(x_nxt, y_nxt);
      end
      glos_pkg::S_CHECK: begin
        if (blocked) begin
          res_nxt = 1'b0;
        end else if (at_end) begin
          res_nxt = 1'b1;
        end
      end
      glos_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = res_r;
        end
      end
      default: begin
        res_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glos_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    tx_r          <= tx_nxt;
    ty_r          <= ty_nxt;
    a_maj_r       <= a_maj_nxt;
    a_min_r       <= a_min_nxt;
    oct_x_r       <= oct_x_nxt;
    x_neg_r       <= x_neg_nxt;
    y_neg_r       <= y_neg_nxt;
    x_mv_r        <= x_mv_nxt;
    y_mv_r        <= y_mv_nxt;
    e_r           <= e_nxt;
    tau_r         <= tau_nxt;
    goal_r        <= goal_nxt;
    res_r         <= res_nxt;
    out_visible_r <= out_visible_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  // A step is always followed by the check of the cell it read.
  a_step_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == glos_pkg::S_STEP |=> state_r == glos_pkg::S_CHECK)
    else $error("walk step not followed by a cell check");

  // A grid write transaction answers not visible in the next cycle.
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !is_query) |=> (out_valid_r && !out_visible_r))
    else $error("grid write did not produce a zero result");

  // The error term stays within its bounded range.
  a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == glos_pkg::S_CHECK |-> (e_r <= 12'sd510 && e_r >= -12'sd510))
    else $error("walk error term out of range");

  // A clear walk finishes only on the goal cell.
  a_clear_at_goal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glos_pkg::S_CHECK && state_nxt == glos_pkg::S_DONE && res_nxt)
      |-> (x_r == tx_r && y_r == ty_r))
    else $error("walk reported visible away from the goal cell");

endmodule

// ----- hdl/grid_line_of_sight_check_core.sv -----
// A grid write returns its result in the cycle after it is taken.
// A query reads the goal cell cost, then steps cell by cell, with one cost memory
// read and one check per step, until a cell blocks the walk or the goal is reached.
// One transaction is in work at a time; the walk loop over the memory port sets the rate.
// Reset clears the sequencer and result valid and sets the threshold to 254;
// the cost grid is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// Grid line-of-sight check core
// Cost grid memory with write loading and line-of-sight queries.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [7:0]              cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [7:0]              in_cell_x,
  input  logic [7:0]              in_cell_y,
  input  logic [7:0]              in_cell_cost,
  input  logic [7:0]              in_from_x,
  input  logic [7:0]              in_from_y,
  input  logic [7:0]              in_to_x,
  input  logic [7:0]              in_to_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_visible
);

  glos_pkg::cost_t    thresh_r, thresh_nxt;
  glos_pkg::ram_req_t ram_req;
  glos_pkg::cost_t    ram_rd_data;

  // Obstacle threshold register.
  assign thresh_nxt = cfg_wr_en ? cfg_wr_data : thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= glos_pkg::THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  // Walk sequencer.
  glos_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .threshold    (thresh_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_cell_cost (in_cell_cost),
    .in_from_x    (in_from_x),
    .in_from_y    (in_from_y),
    .in_to_x      (in_to_x),
    .in_to_y      (in_to_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_visible  (out_visible),
    .ram_req      (ram_req),
    .ram_rd_data  (ram_rd_data)
  );

  // Cost grid storage.
  glos_cost_ram u_cost_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

endmodule

// ----- verif/los_result_checker.sv -----
// ----------------------------------------------------------------------------
// Line-of-sight result checker
// Watches the input, result and register ports of the line-of-sight core. It
// keeps its own copy of the cost grid and the obstacle threshold, works out
// the visibility answer of every accepted transaction and compares it with
// the result stream in order.
// ----------------------------------------------------------------------------
module los_result_checker
  import glos_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_cell_x,
  input  logic [7:0] in_cell_y,
  input  logic [7:0] in_cell_cost,
  input  logic [7:0] in_from_x,
  input  logic [7:0] in_from_y,
  input  logic [7:0] in_to_x,
  input  logic [7:0] in_to_y,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_visible,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the grid and the threshold register.
  cost_t grid_cost [MAP_CELLS];
  cost_t block_level = THRESH_RESET;

  // Visibility answers still owed by the block, oldest first.
  logic visible_owed [$];
  int   mismatches = 0;

  // Cost of a cell; cells off the grid read as zero.
  function automatic cost_t cost_of(int x, int y);
    if (x < 0 || y < 0 || x >= MAP_WIDTH || y >= MAP_HEIGHT) begin
      return '0;
    end
    return grid_cost[y * MAP_WIDTH + x];
  endfunction

  // A cell stops the walk when it reaches both the threshold and the goal cost.
  function automatic logic stops_at(int x, int y, cost_t goal);
    cost_t c;
    c = cost_of(x, y);
    return (c >= block_level) && (c >= goal);
  endfunction

  // Walks from the from cell toward the to cell and tells whether it gets through.
  function automatic logic line_visible(int fx, int fy, int tx, int ty);
    int    dx, dy, sx, sy, ax, ay, x, y, e, tau;
    cost_t goal;
    if (fx >= MAP_WIDTH || fy >= MAP_HEIGHT || tx >= MAP_WIDTH || ty >= MAP_HEIGHT) begin
      return 1'b0;
    end
    dx = tx - fx;
    dy = ty - fy;
    sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    x = fx;
    y = fy;
    e = 0;
    goal = cost_of(tx, ty);
    if (ax > ay) begin
      // Mostly horizontal walk.
      tau = ay - ax;
      while (x != tx) begin
        if (2 * e > tau) begin
          x += sx;
          e -= ay;
        end else if (2 * e < tau) begin
          y += sy;
          e += ax;
        end else begin
          x += sx;
          y += sy;
          e += ax - ay;
        end
        if (stops_at(x, y, goal)) return 1'b0;
      end
    end else begin
      // Mostly vertical walk; equal spans land here and step diagonally.
      tau = ax - ay;
      while (y != ty) begin
        if (2 * e > tau) begin
          y += sy;
          e -= ax;
        end else if (2 * e < tau) begin
          x += sx;
          e += ay;
        end else begin
          x += sx;
          y += sy;
          e += ay - ax;
        end
        if (stops_at(x, y, goal)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Track register writes, predict each accepted transaction, compare each result.
  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      block_level = THRESH_RESET;
      visible_owed.delete();
    end else begin
      if (cfg_wr_en) begin
        block_level = cost_t'(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        if (op_t'(in_operation) == OP_WRITE) begin
          if (int'(in_cell_x) < MAP_WIDTH && int'(in_cell_y) < MAP_HEIGHT) begin
            grid_cost[int'(in_cell_y) * MAP_WIDTH + int'(in_cell_x)] = in_cell_cost;
          end
          visible_owed = {visible_owed, 1'b0};
        end else begin
          visible_owed = {visible_owed, line_visible(int'(in_from_x), int'(in_from_y),
                                                     int'(in_to_x), int'(in_to_y))};
        end
      end
      if (out_valid && !out_stall) begin
        if (visible_owed.size() == 0) begin
          $error("visible: result with no transaction pending, actual %0b", out_visible);
          mismatches++;
        end else begin
          want = visible_owed.pop_front();
          if (out_visible !== want) begin
            $error("visible: expected %0b actual %0b", want, out_visible);
            mismatches++;
          end
        end
      end
    end
    pending_count <= visible_owed.size();
    fail_count    <= mismatches;
  end

endmodule

// ----- verif/grid_line_of_sight_check_core_test.sv -----
// ----------------------------------------------------------------------------
// Line-of-sight core testbench
// Loads the cost grid and sends line-of-sight queries under several obstacle
// thresholds and idle patterns. Every query only touches cells that were
// loaded first. A checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glos_pkg::*;

  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 234;
  localparam int COORD_MAX       = MAP_WIDTH - 1;
  localparam int DRAIN_CYCLES    = 1100;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic       in_operation;
  logic [7:0] in_cell_x;
  logic [7:0] in_cell_y;
  logic [7:0] in_cell_cost;
  logic [7:0] in_from_x;
  logic [7:0] in_from_y;
  logic [7:0] in_to_x;
  logic [7:0] in_to_y;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_visible;
  int         fail_count;
  int         pending_count;

  int in_idle_pct    = 32;
  int out_idle_pct   = 60;
  int threshold_now  = 254;
  int items_sent     = 0;
  bit loaded [MAP_CELLS];
  int anchor_x [5]   = '{0, COORD_MAX, 0, COORD_MAX, 128};
  int anchor_y [5]   = '{0, 0, COORD_MAX, COORD_MAX, 127};

  grid_line_of_sight_check_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_cell_x    (in_cell_x),
    .in_cell_y    (in_cell_y),
    .in_cell_cost (in_cell_cost),
    .in_from_x    (in_from_x),
    .in_from_y    (in_from_y),
    .in_to_x      (in_to_x),
    .in_to_y      (in_to_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_visible  (out_visible)
  );

  los_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_cost  (in_cell_cost),
    .in_from_x     (in_from_x),
    .in_from_y     (in_from_y),
    .in_to_x       (in_to_x),
    .in_to_y       (in_to_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_visible   (out_visible),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // Run watchdog.
  initial begin
    #(60_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Cost mix: many free cells, some near-lethal ones, some around the threshold, the rest at random.
  function automatic cost_t pick_cost();
    int r;
    r = $urandom_range(99);
    if (r < 40) return cost_t'($urandom_range(20));
    if (r < 60) return cost_t'($urandom_range(255, 250));
    if (r < 80) return cost_t'(clip(threshold_now + int'($urandom_range(4)) - 2, 255));
    return cost_t'($urandom_range(255));
  endfunction

  // Offer one transaction, with a random idle gap in front, and wait for acceptance.
  task automatic send_item(input op_t op, input coord_t cx, input coord_t cy,
                           input cost_t cc, input coord_t fx, input coord_t fy,
                           input coord_t tx, input coord_t ty);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_cell_x    <= cx;
    in_cell_y    <= cy;
    in_cell_cost <= cc;
    in_from_x    <= fx;
    in_from_y    <= fy;
    in_to_x      <= tx;
    in_to_y      <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Grid write; the query fields carry random filler.
  task automatic write_cell(input int x, input int y, input cost_t c);
    send_item(OP_WRITE, coord_t'(x), coord_t'(y), c, coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    loaded[y * MAP_WIDTH + x] = 1'b1;
  endtask

  // Query; every cell of the bounding box is loaded first, since the walk stays in it.
  task automatic query_line(input int fx, input int fy, input int tx, input int ty);
    int x0, x1, y0, y1;
    x0 = (fx < tx) ? fx : tx;
    x1 = (fx < tx) ? tx : fx;
    y0 = (fy < ty) ? fy : ty;
    y1 = (fy < ty) ? ty : fy;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        if (!loaded[y * MAP_WIDTH + x]) write_cell(x, y, pick_cost());
      end
    end
    send_item(OP_QUERY, coord_t'($urandom), coord_t'($urandom), cost_t'($urandom),
              coord_t'(fx), coord_t'(fy), coord_t'(tx), coord_t'(ty));
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Threshold changes only while the block is idle.
  task automatic set_threshold(input int level);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 8'(level);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold_now = level;
  endtask

  // One random transaction: mostly queries near a few hot spots, some stray writes.
  task automatic random_transaction();
    int r, k, fx, fy, spx, spy, t;
    k = $urandom_range(5);
    if (k == 5) begin
      fx = $urandom_range(COORD_MAX);
      fy = $urandom_range(COORD_MAX);
    end else begin
      fx = clip(anchor_x[k] + int'($urandom_range(12)) - 6, COORD_MAX);
      fy = clip(anchor_y[k] + int'($urandom_range(12)) - 6, COORD_MAX);
    end
    r = $urandom_range(99);
    if (r < 12) begin
      write_cell(fx, fy, pick_cost());
    end else begin
      r = $urandom_range(99);
      if (r < 55) begin
        spx = $urandom_range(3);
        spy = $urandom_range(3);
      end else if (r < 80) begin
        // Long thin lines exercise many same-direction steps.
        spx = $urandom_range(40, 4);
        spy = $urandom_range(2);
        if ($urandom_range(1)) begin
          t   = spx;
          spx = spy;
          spy = t;
        end
      end else if (r < 92) begin
        spx = $urandom_range(8, 1);
        spy = spx;
      end else begin
        spx = $urandom_range(8);
        spy = $urandom_range(8);
      end
      if ($urandom_range(1)) spx = -spx;
      if ($urandom_range(1)) spy = -spy;
      query_line(fx, fy, clip(fx + spx, COORD_MAX), clip(fy + spy, COORD_MAX));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int levels [PHASES];
    levels = '{254, 255, 0, 0, 128};
    levels[3] = $urandom_range(253, 1);
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_operation <= OP_WRITE;
    in_cell_x    <= '0;
    in_cell_y    <= '0;
    in_cell_cost <= '0;
    in_from_x    <= '0;
    in_from_y    <= '0;
    in_to_x      <= '0;
    in_to_y      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        in_idle_pct  = 32;
        out_idle_pct = 60;
      end else if (p < 4) begin
        in_idle_pct  = 60;
        out_idle_pct = 32;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (p > 0) begin
        set_threshold(levels[p]);
      end else begin
        // Directed cases at the reset threshold, near both grid corners.
        write_cell(0, 0, 8'd0);
        write_cell(1, 0, 8'd255);
        write_cell(2, 0, 8'd10);
        write_cell(0, 1, 8'd0);
        write_cell(1, 1, 8'd0);
        // Lethal cell in the middle of a pure x run.
        query_line(0, 0, 2, 0);
        // Equal spans, a single diagonal step.
        query_line(0, 0, 1, 1);
        // From and to are the same cell.
        query_line(0, 0, 0, 0);
        // The goal cell itself is lethal.
        query_line(0, 0, 1, 0);
        // Negative x direction over the lethal cell.
        query_line(2, 0, 0, 0);
        write_cell(COORD_MAX, COORD_MAX, 8'd254);
        write_cell(COORD_MAX - 1, COORD_MAX - 1, 8'd0);
        write_cell(COORD_MAX - 1, COORD_MAX, 8'd0);
        write_cell(COORD_MAX, COORD_MAX - 1, 8'd0);
        // The from cell is never checked, the goal is.
        query_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 1);
        query_line(COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX);
        query_line(COORD_MAX, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX);
        // Mixed steps in the x-major and y-major cases.
        query_line(0, 0, 2, 1);
        query_line(0, 0, 1, 2);
        query_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1);
      end
      while (items_sent < (p + 1) * ITEMS_PER_PHASE) random_transaction();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
